/* src/pac_pkg.sv */
package pac_pkg;

  // Field widths.
  localparam int COORD_W    = 16;
  localparam int AREA_OUT_W = 40;
  localparam int STATUS_W   = 2;

  // Accumulator widths; the sums wrap at these widths.
  localparam int AREA_W = 44;
  localparam int MOM_W  = 61;

  // Vertex count saturates at this value.
  localparam int MAX_VERTICES = 1024;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int MIN_VERTICES = 3;

  // Shared multiplier: a 17-bit operand (a coordinate or a coordinate sum)
  // against a 33-bit operand (a coordinate or an edge cross product).
  localparam int MUL_A_W = COORD_W + 1;
  localparam int MUL_B_W = 2 * COORD_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int CROSS_W = MUL_B_W;

  // Divider: numerator is 2*|moment| + 3*|2A|, divisor is 6*|2A|.
  localparam int D3_W   = AREA_W + 2;
  localparam int DEN_W  = D3_W + 1;
  localparam int NUM_W  = MOM_W + 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int DCNT_W = $clog2(NUM_W);

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
  localparam logic [AREA_OUT_W-1:0]     AREA_MAX  = '1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [AREA_OUT_W-1:0]     area_out_t;
  typedef logic [STATUS_W-1:0]       status_t;

  // Divider handshake towards the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* src/pac_if.sv */
interface pac_in_if;
  logic            valid;
  logic            ready;
  pac_pkg::coord_t vertex_x;
  pac_pkg::coord_t vertex_y;
  logic            last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                output ready);
endinterface

interface pac_out_if;
  logic               valid;
  logic               ready;
  pac_pkg::area_out_t area;
  pac_pkg::coord_t    centroid_x;
  pac_pkg::coord_t    centroid_y;
  pac_pkg::status_t   status;

  modport source (output valid, output area, output centroid_x, output centroid_y,
                  output status, input ready);
  modport sink (input valid, input area, input centroid_x, input centroid_y,
                input status, output ready);
endinterface

/* src/polygon_area_centroid.sv */
// Streaming shoelace area and centroid of a polygon.
//
// Vertices arrive as beats on in_chan: signed 16-bit x and y (fixed point,
// four fraction bits) and a last_vertex flag that closes the polygon. Each
// polygon gives one result beat on out_chan: the absolute area with twice
// the fraction bits, the centroid in the input format, and a status (ok,
// fewer than three vertices, or zero area, the latter two with a zero
// centroid). The block handles one vertex at a time and drops in_chan.ready
// while it works. The first vertex of a polygon is stored; every other
// vertex runs four dependent products on the single shared multiplier plus
// the subtract and the two moment accumulations. The last vertex also runs
// the closing edge and then, when the status is ok, two 62-step divisions
// on the bit-serial divider. The result sits in an output register; the
// next polygon's vertices are taken while it waits, and only the next
// result waits for out_chan.ready. A synchronous active-low reset clears
// the sequencer, the vertex count, the sums and the output valid; no
// clearing pass is needed.
module polygon_area_centroid (
  input  logic       clk,
  input  logic       rst_n,
  pac_in_if.sink     in_chan,
  pac_out_if.source  out_chan
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL_A  = 4'd1;   // ax*by
  localparam logic [3:0] S_MUL_B  = 4'd2;   // bx*ay
  localparam logic [3:0] S_CROSS  = 4'd3;   // edge cross product, area sum
  localparam logic [3:0] S_MUL_X  = 4'd4;   // (ax+bx)*cross
  localparam logic [3:0] S_MUL_Y  = 4'd5;   // (ay+by)*cross, x moment sum
  localparam logic [3:0] S_ACC_Y  = 4'd6;   // y moment sum
  localparam logic [3:0] S_PREP   = 4'd7;   // magnitude of the signed area
  localparam logic [3:0] S_SCALE  = 4'd8;   // 3*|2A|, area output, status
  localparam logic [3:0] S_LDN    = 4'd9;   // magnitude of the moment
  localparam logic [3:0] S_LDD    = 4'd10;  // divider start
  localparam logic [3:0] S_DIV    = 4'd11;
  localparam logic [3:0] S_DIVEND = 4'd12;  // saturate, sign, store centroid
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Polygon state.
  pac_pkg::coord_t                first_x_r, first_y_r;
  pac_pkg::coord_t                prev_x_r, prev_y_r;
  logic [pac_pkg::CNT_W-1:0]      count_r;
  logic [pac_pkg::AREA_W-1:0]     area_sum_r;
  logic [pac_pkg::MOM_W-1:0]      mom_x_r, mom_y_r;

  // Edge under work: a -> b.
  pac_pkg::coord_t                ax_r, ay_r, bx_r, by_r;
  logic                           last_r;
  logic                           close_r;
  logic signed [pac_pkg::CROSS_W-1:0] p1_r;
  logic signed [pac_pkg::CROSS_W-1:0] cross_r;
  logic signed [pac_pkg::MUL_A_W-1:0] sx_r, sy_r;

  // Closing arithmetic.
  logic [pac_pkg::AREA_W-1:0]     abs_s_r;
  logic                           s_neg_r;
  logic [pac_pkg::D3_W-1:0]       d3_r;
  logic [pac_pkg::MOM_W-1:0]      n_r;
  logic                           m_neg_r;
  logic                           axis_r;
  pac_pkg::status_t               status_r;
  pac_pkg::area_out_t             area_r;
  pac_pkg::coord_t                cx_r, cy_r;

  // Output register.
  logic                           out_valid_r;
  pac_pkg::area_out_t             out_area_r;
  pac_pkg::coord_t                out_cx_r, out_cy_r;
  pac_pkg::status_t               out_status_r;

  // Shared units.
  logic signed [pac_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pac_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pac_pkg::PROD_W-1:0]  prod;
  logic                               div_start;
  logic [pac_pkg::NUM_W-1:0]          div_num;
  logic [pac_pkg::DEN_W-1:0]          div_den;
  logic [pac_pkg::NUM_W-1:0]          quot;
  pac_pkg::div_sts_t                  div_sts;

  logic                               in_acc;
  logic                               out_free;
  logic signed [pac_pkg::CROSS_W-1:0] cross_nxt;
  logic [pac_pkg::AREA_W:0]           area_rnd;
  logic [pac_pkg::MOM_W-1:0]          mom_sel;
  logic                               q_neg;
  pac_pkg::coord_t                    cent;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  pac_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  pac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (quot),
    .sts   (div_sts)
  );

  // Operand selection for the multiplier: coordinates are sign-extended to
  // the operand widths, the second pass multiplies the stored cross product.
  always_comb begin
    case (state_r)
      S_MUL_A: begin
        mul_a = {ax_r[pac_pkg::COORD_W-1], ax_r};
        mul_b = {{(pac_pkg::MUL_B_W - pac_pkg::COORD_W){by_r[pac_pkg::COORD_W-1]}}, by_r};
      end
      S_MUL_B: begin
        mul_a = {bx_r[pac_pkg::COORD_W-1], bx_r};
        mul_b = {{(pac_pkg::MUL_B_W - pac_pkg::COORD_W){ay_r[pac_pkg::COORD_W-1]}}, ay_r};
      end
      S_MUL_X: begin
        mul_a = sx_r;
        mul_b = cross_r;
      end
      S_MUL_Y: begin
        mul_a = sy_r;
        mul_b = cross_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    cross_nxt = p1_r - prod[pac_pkg::CROSS_W-1:0];
    // Half of |2A|, rounded half up.
    area_rnd  = {1'b0, abs_s_r} + 1'b1;
    mom_sel   = axis_r ? mom_y_r : mom_x_r;
    div_start = (state_r == S_LDD);
    // Numerator 2n + d and divisor 2d give round-to-nearest, ties away.
    div_num   = {n_r, 1'b0} + pac_pkg::NUM_W'(d3_r);
    div_den   = {d3_r, 1'b0};
    q_neg     = m_neg_r ^ s_neg_r;
    if (q_neg) begin
      if (quot > pac_pkg::NUM_W'(32768)) begin
        cent = pac_pkg::COORD_MIN;
      end else begin
        cent = pac_pkg::COORD_W'(16'd0 - quot[pac_pkg::COORD_W-1:0]);
      end
    end else begin
      if (quot > pac_pkg::NUM_W'(32767)) begin
        cent = pac_pkg::COORD_MAX;
      end else begin
        cent = quot[pac_pkg::COORD_W-1:0];
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && ((count_r != '0) || in_chan.last_vertex)) begin
          state_nxt = S_MUL_A;
        end
      end
      S_MUL_A: state_nxt = S_MUL_B;
      S_MUL_B: state_nxt = S_CROSS;
      S_CROSS: state_nxt = S_MUL_X;
      S_MUL_X: state_nxt = S_MUL_Y;
      S_MUL_Y: state_nxt = S_ACC_Y;
      S_ACC_Y: begin
        if (last_r && !close_r) begin
          state_nxt = S_MUL_A;
        end else if (last_r) begin
          state_nxt = S_PREP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PREP:  state_nxt = S_SCALE;
      S_SCALE: begin
        if ((count_r < pac_pkg::CNT_W'(pac_pkg::MIN_VERTICES)) || (abs_s_r == '0)) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_LDN;
        end
      end
      S_LDN:   state_nxt = S_LDD;
      S_LDD:   state_nxt = S_DIV;
      S_DIV: begin
        if (div_sts.done) begin
          state_nxt = S_DIVEND;
        end
      end
      S_DIVEND: state_nxt = axis_r ? S_OUT : S_LDN;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      area_sum_r  <= '0;
      mom_x_r     <= '0;
      mom_y_r     <= '0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (in_acc) begin
        if (count_r == '0) begin
          first_x_r  <= in_chan.vertex_x;
          first_y_r  <= in_chan.vertex_y;
          area_sum_r <= '0;
          mom_x_r    <= '0;
          mom_y_r    <= '0;
        end
        prev_x_r <= in_chan.vertex_x;
        prev_y_r <= in_chan.vertex_y;
        if (count_r != pac_pkg::CNT_W'(pac_pkg::MAX_VERTICES)) begin
          count_r <= count_r + 1'b1;
        end
      end

      if (state_r == S_CROSS) begin
        area_sum_r <= area_sum_r +
          {{(pac_pkg::AREA_W - pac_pkg::CROSS_W){cross_nxt[pac_pkg::CROSS_W-1]}}, cross_nxt};
      end
      if (state_r == S_MUL_Y) begin
        mom_x_r <= mom_x_r +
          {{(pac_pkg::MOM_W - pac_pkg::PROD_W){prod[pac_pkg::PROD_W-1]}}, prod};
      end
      if (state_r == S_ACC_Y) begin
        mom_y_r <= mom_y_r +
          {{(pac_pkg::MOM_W - pac_pkg::PROD_W){prod[pac_pkg::PROD_W-1]}}, prod};
      end

      // The result goes out and the polygon state is cleared for the next one.
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
        count_r     <= '0;
        area_sum_r  <= '0;
        mom_x_r     <= '0;
        mom_y_r     <= '0;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          last_r <= in_chan.last_vertex;
          bx_r   <= in_chan.vertex_x;
          by_r   <= in_chan.vertex_y;
          if (count_r == '0) begin
            // A lone last vertex closes on itself.
            ax_r    <= in_chan.vertex_x;
            ay_r    <= in_chan.vertex_y;
            close_r <= 1'b1;
          end else begin
            ax_r    <= prev_x_r;
            ay_r    <= prev_y_r;
            close_r <= 1'b0;
          end
        end
      end
      S_MUL_B: p1_r <= prod[pac_pkg::CROSS_W-1:0];
      S_CROSS: begin
        cross_r <= cross_nxt;
        sx_r    <= {ax_r[pac_pkg::COORD_W-1], ax_r} + {bx_r[pac_pkg::COORD_W-1], bx_r};
        sy_r    <= {ay_r[pac_pkg::COORD_W-1], ay_r} + {by_r[pac_pkg::COORD_W-1], by_r};
      end
      S_ACC_Y: begin
        // Closing edge runs from the last vertex back to the first.
        if (last_r && !close_r) begin
          ax_r    <= prev_x_r;
          ay_r    <= prev_y_r;
          bx_r    <= first_x_r;
          by_r    <= first_y_r;
          close_r <= 1'b1;
        end
      end
      S_PREP: begin
        s_neg_r <= area_sum_r[pac_pkg::AREA_W-1];
        abs_s_r <= area_sum_r[pac_pkg::AREA_W-1] ? (pac_pkg::AREA_W'(0) - area_sum_r)
                                                : area_sum_r;
      end
      S_SCALE: begin
        d3_r   <= {2'b00, abs_s_r} + {1'b0, abs_s_r, 1'b0};
        area_r <= (area_rnd[pac_pkg::AREA_W:pac_pkg::AREA_OUT_W+1] != '0)
                  ? pac_pkg::AREA_MAX : area_rnd[pac_pkg::AREA_OUT_W:1];
        cx_r   <= '0;
        cy_r   <= '0;
        axis_r <= 1'b0;
        if (count_r < pac_pkg::CNT_W'(pac_pkg::MIN_VERTICES)) begin
          status_r <= pac_pkg::ST_FEW;
        end else if (abs_s_r == '0) begin
          status_r <= pac_pkg::ST_ZERO;
        end else begin
          status_r <= pac_pkg::ST_OK;
        end
      end
      S_LDN: begin
        m_neg_r <= mom_sel[pac_pkg::MOM_W-1];
        n_r     <= mom_sel[pac_pkg::MOM_W-1] ? (pac_pkg::MOM_W'(0) - mom_sel) : mom_sel;
      end
      S_DIVEND: begin
        if (axis_r) begin
          cy_r <= cent;
        end else begin
          cx_r <= cent;
        end
        axis_r <= 1'b1;
      end
      S_OUT: begin
        if (out_free) begin
          out_area_r   <= area_r;
          out_cx_r     <= cx_r;
          out_cy_r     <= cy_r;
          out_status_r <= status_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.area       = out_area_r;
  assign out_chan.centroid_x = out_cx_r;
  assign out_chan.centroid_y = out_cy_r;
  assign out_chan.status     = out_status_r;

endmodule

/* src/pac_mul.sv */
// Shared signed multiplier with a registered product.
module pac_mul (
  input  logic                                 clk,
  input  logic signed [pac_pkg::MUL_A_W-1:0]   mul_a,
  input  logic signed [pac_pkg::MUL_B_W-1:0]   mul_b,
  output logic signed [pac_pkg::PROD_W-1:0]    prod
);

  logic signed [pac_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod = prod_r;

endmodule

/* src/pac_div.sv */
// Restoring divider, one quotient bit per cycle. The numerator register
// shifts out at the top while quotient bits shift in at the bottom.
module pac_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pac_pkg::NUM_W-1:0]     num,
  input  logic [pac_pkg::DEN_W-1:0]     den,
  output logic [pac_pkg::NUM_W-1:0]     quot,
  output pac_pkg::div_sts_t             sts
);

  logic [pac_pkg::NUM_W-1:0]  qn_r;
  logic [pac_pkg::DEN_W-1:0]  den_r;
  logic [pac_pkg::REM_W-1:0]  rem_r;
  logic [pac_pkg::DCNT_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [pac_pkg::REM_W-1:0] rem_sh;
  logic [pac_pkg::REM_W-1:0] den_ext;
  logic                      fits;

  always_comb begin
    rem_sh  = {rem_r[pac_pkg::REM_W-2:0], qn_r[pac_pkg::NUM_W-1]};
    den_ext = {1'b0, den_r};
    fits    = (rem_sh >= den_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == pac_pkg::DCNT_W'(pac_pkg::NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
      cnt_r <= cnt_r + 1'b1;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qn_r  <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - den_ext) : rem_sh;
      qn_r  <= {qn_r[pac_pkg::NUM_W-2:0], fits};
    end
  end

  assign quot     = qn_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* src/pac_chk.sv */
module pac_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_last,
  input logic                      out_valid,
  input logic                      out_ready,
  input pac_pkg::area_out_t        area,
  input pac_pkg::coord_t           centroid_x,
  input pac_pkg::coord_t           centroid_y,
  input pac_pkg::status_t          status
);

  // Nothing is offered straight after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(area) && $stable(centroid_x)
                                && $stable(centroid_y) && $stable(status))
    else $error("stalled result changed");

  // A failed polygon reads a zero centroid.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != pac_pkg::ST_OK) |-> (centroid_x == '0) && (centroid_y == '0))
    else $error("centroid not zero on error status");

  // A good polygon has a non-zero area.
  a_ok_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == pac_pkg::ST_OK) |-> (area != '0))
    else $error("zero area with ok status");

  // Closing a polygon keeps the input side busy.
  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("ready straight after the last vertex");

endmodule

bind polygon_area_centroid pac_chk u_pac_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_last    (in_chan.last_vertex),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .area       (out_chan.area),
  .centroid_x (out_chan.centroid_x),
  .centroid_y (out_chan.centroid_y),
  .status     (out_chan.status)
);

/* test/polygon_area_centroid_tb.sv */
module polygon_area_centroid_tb;
  import pac_pkg::*;

  // The random part stops once about this many vertex beats have been sent.
  // In the final stretch of it neither side idles, so the block is also seen
  // running flat out.
  localparam int RANDOM_ITEMS = 780;
  localparam int CALM_ITEMS   = 150;

  // Laps of the full-range square for the long polygon. Each lap adds about
  // 2^33 to twice the area, so 260 laps push the area past the 40-bit output
  // and the vertex count past its saturation point.
  localparam int SQUARE_LAPS = 260;

  // Ample for draining the work of a closing vertex, divisions included.
  localparam int DRAIN_CYCLES = 300;

  // The limit is set to clear the slowest correct run (every beat a one-vertex
  // polygon, each behind the longest sender gap and the longest receiver stall).
  localparam int CYCLE_LIMIT = 2_000_000;

  // Flavours of random polygon.
  typedef enum int {
    SHAPE_WILD,
    SHAPE_CLUSTER,
    SHAPE_EXTREME,
    SHAPE_LINE,
    SHAPE_RECT,
    SHAPE_POINT
  } shape_e;

  typedef struct {
    area_out_t area;
    coord_t    cx;
    coord_t    cy;
    status_t   status;
  } poly_result_t;

  // One row of stimulus. Where fixed is set, the closing vertex carries a
  // hand-written expectation in res in place of the predicted one.
  typedef struct {
    coord_t       x;
    coord_t       y;
    logic         last;
    bit           fixed;
    poly_result_t res;
  } vertex_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pac_in_if  vertex_beats ();
  pac_out_if result_beats ();

  polygon_area_centroid dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (vertex_beats),
    .out_chan (result_beats)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block's polygon state, kept in step with every
  // accepted vertex beat.
  coord_t            first_x, first_y, prev_x, prev_y;
  int unsigned       vertex_count;
  logic [AREA_W-1:0] twice_area;
  logic [MOM_W-1:0]  moment_x, moment_y;

  poly_result_t pending_results[$];
  vertex_row_t  directed_rows[$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           idle_on     = 1'b1;

  // One shoelace edge from a to b: the cross product feeds twice the area,
  // and the cross product weighted by the coordinate sums feeds the moments.
  // All three sums wrap at their register widths.
  function automatic void add_edge(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    logic signed [63:0] xprod, mx, my;
    xprod = longint'(ax) * longint'(by) - longint'(bx) * longint'(ay);
    mx = (longint'(ax) + longint'(bx)) * xprod;
    my = (longint'(ay) + longint'(by)) * xprod;
    twice_area = twice_area + xprod[AREA_W-1:0];
    moment_x   = moment_x + mx[MOM_W-1:0];
    moment_y   = moment_y + my[MOM_W-1:0];
  endfunction

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // Centroid coordinate: moment / (3 * twice the signed area), rounded to
  // nearest with ties away from zero, then clamped to the coordinate range.
  // Dividing by the signed area keeps clockwise polygons right.
  function automatic coord_t centroid_div(logic signed [63:0] num,
                                          logic signed [63:0] den);
    logic [63:0] n, d, q;
    bit          neg;
    n   = magnitude(num);
    d   = 64'd3 * magnitude(den);
    neg = (num < 0) != (den < 0);
    q   = (64'd2 * n + d) / (64'd2 * d);
    if (neg) begin
      if (q > 64'd32768) q = 64'd32768;
      q = -q;
    end else if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return coord_t'(q[COORD_W-1:0]);
  endfunction

  // Folds one accepted vertex into the shadow state. Returns 1 and fills res
  // when the vertex closes the polygon.
  function automatic bit shoelace_step(coord_t x, coord_t y, logic last,
                                       output poly_result_t res);
    logic signed [63:0] s, mxs, mys;
    logic [63:0]        a;
    res.area   = '0;
    res.cx     = '0;
    res.cy     = '0;
    res.status = ST_OK;
    if (vertex_count == 0) begin
      first_x    = x;
      first_y    = y;
      twice_area = '0;
      moment_x   = '0;
      moment_y   = '0;
    end else begin
      add_edge(prev_x, prev_y, x, y);
    end
    prev_x = x;
    prev_y = y;
    if (vertex_count < MAX_VERTICES) vertex_count++;
    if (!last) return 1'b0;

    // Closing edge back to the first vertex.
    add_edge(x, y, first_x, first_y);
    s   = $signed(twice_area);
    mxs = $signed(moment_x);
    mys = $signed(moment_y);

    // Half of twice the area, rounding half up, clamped to the output width.
    a = (magnitude(s) + 64'd1) >> 1;
    res.area = (a > 64'(AREA_MAX)) ? AREA_MAX : a[AREA_OUT_W-1:0];
    if (vertex_count < MIN_VERTICES) begin
      res.status = ST_FEW;
    end else if (s == 0) begin
      res.status = ST_ZERO;
    end else begin
      res.cx = centroid_div(mxs, s);
      res.cy = centroid_div(mys, s);
    end

    vertex_count = 0;
    twice_area   = '0;
    moment_x     = '0;
    moment_y     = '0;
    return 1'b1;
  endfunction

  // Rows with a typed expectation only ever carry an error status, so their
  // centroid is always zero.
  function automatic void add_row(coord_t x, coord_t y, logic last, bit fixed = 1'b0,
                                  area_out_t area = '0, status_t status = ST_OK);
    vertex_row_t r;
    r.x          = x;
    r.y          = y;
    r.last       = last;
    r.fixed      = fixed;
    r.res.area   = area;
    r.res.cx     = '0;
    r.res.cy     = '0;
    r.res.status = status;
    directed_rows.push_back(r);
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return coord_t'(0);
      3:       return coord_t'(-1);
      default: return coord_t'(1);
    endcase
  endfunction

  // Drives one vertex beat from a falling edge and holds it until the block
  // takes it. The expectation is queued at the edge of acceptance, long before
  // the result can appear. Valid is left high on return; the next call either
  // keeps it high or opens an idle gap.
  task automatic send_vertex(input vertex_row_t r);
    poly_result_t res;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      vertex_beats.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    vertex_beats.valid       = 1'b1;
    vertex_beats.vertex_x    = r.x;
    vertex_beats.vertex_y    = r.y;
    vertex_beats.last_vertex = r.last;
    do @(posedge clk); while (!vertex_beats.ready);
    if (shoelace_step(r.x, r.y, r.last, res))
      pending_results.push_back(r.fixed ? r.res : res);
    @(negedge clk);
  endtask

  // Result side: ready is dropped in random bursts so that a finished result
  // sometimes has to wait in the output register.
  initial begin
    result_beats.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 11) == 0) begin
        result_beats.ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        result_beats.ready = 1'b1;
      end
    end
  end

  // Every result beat is matched against the oldest waiting expectation.
  always @(posedge clk) begin : check_results
    poly_result_t want;
    if (rst_n && result_beats.valid && result_beats.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_beats.area !== want.area) begin
          $error("area: expected %0d, got %0d", want.area, result_beats.area);
          error_count++;
        end
        if (result_beats.centroid_x !== want.cx) begin
          $error("centroid_x: expected %0d, got %0d", want.cx, result_beats.centroid_x);
          error_count++;
        end
        if (result_beats.centroid_y !== want.cy) begin
          $error("centroid_y: expected %0d, got %0d", want.cy, result_beats.centroid_y);
          error_count++;
        end
        if (result_beats.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_beats.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    vertex_row_t r;
    shape_e      shape;
    int          random_sent, n, roll, k;
    int          base_x, base_y, step_x, step_y;
    coord_t      far_x, far_y;

    vertex_beats.valid       = 1'b0;
    vertex_beats.vertex_x    = '0;
    vertex_beats.vertex_y    = '0;
    vertex_beats.last_vertex = 1'b0;
    first_x      = '0;
    first_y      = '0;
    prev_x       = '0;
    prev_y       = '0;
    vertex_count = 0;
    twice_area   = '0;
    moment_x     = '0;
    moment_y     = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table. A lone vertex closes on itself, and two vertices give
    // an edge and its return that cancel, so both read as too few vertices
    // with zero area. Collinear and coincident points give zero area.
    add_row(0, 0, 1'b1, 1'b1, '0, ST_FEW);
    add_row(COORD_MAX, COORD_MIN, 1'b1, 1'b1, '0, ST_FEW);
    add_row(COORD_MIN, COORD_MIN, 1'b0);
    add_row(COORD_MAX, COORD_MAX, 1'b1, 1'b1, '0, ST_FEW);
    add_row(0, 0, 1'b0);
    add_row(16, 16, 1'b0);
    add_row(32, 32, 1'b1, 1'b1, '0, ST_ZERO);
    add_row(COORD_MIN, COORD_MIN, 1'b0);
    add_row(COORD_MIN, COORD_MIN, 1'b0);
    add_row(COORD_MIN, COORD_MIN, 1'b1, 1'b1, '0, ST_ZERO);
    // Small triangle wound anticlockwise, then clockwise: same centroid.
    add_row(0, 0, 1'b0);
    add_row(16, 0, 1'b0);
    add_row(0, 16, 1'b1);
    add_row(0, 0, 1'b0);
    add_row(0, 16, 1'b0);
    add_row(16, 0, 1'b1);
    // Full-range square, both windings.
    add_row(COORD_MIN, COORD_MIN, 1'b0);
    add_row(COORD_MAX, COORD_MIN, 1'b0);
    add_row(COORD_MAX, COORD_MAX, 1'b0);
    add_row(COORD_MIN, COORD_MAX, 1'b1);
    add_row(COORD_MIN, COORD_MIN, 1'b0);
    add_row(COORD_MIN, COORD_MAX, 1'b0);
    add_row(COORD_MAX, COORD_MAX, 1'b0);
    add_row(COORD_MAX, COORD_MIN, 1'b1);
    foreach (directed_rows[i]) send_vertex(directed_rows[i]);

    // Long polygon: the full-range square wound many times over. The vertex
    // count saturates and the area clamps at the top of the output range.
    r.fixed = 1'b0;
    for (int i = 0; i < 4 * SQUARE_LAPS; i++) begin
      r.x    = (i % 4 == 1 || i % 4 == 2) ? COORD_MAX : COORD_MIN;
      r.y    = (i % 4 >= 2) ? COORD_MAX : COORD_MIN;
      r.last = (i == 4 * SQUARE_LAPS - 1);
      send_vertex(r);
    end

    // Random polygons. Most are whole polygons with random content; a share
    // is built to hit the error paths (collinear, coincident, one or two
    // vertices) and the extremes of the coordinate range.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (RANDOM_ITEMS - random_sent <= CALM_ITEMS) idle_on = 1'b0;
      roll  = $urandom_range(0, 9);
      shape = (roll < 4) ? SHAPE_WILD :
              (roll < 6) ? SHAPE_CLUSTER :
              (roll == 6) ? SHAPE_EXTREME :
              (roll == 7) ? SHAPE_LINE :
              (roll == 8) ? SHAPE_RECT : SHAPE_POINT;
      roll = $urandom_range(0, 19);
      if (roll < 3)       n = $urandom_range(1, 2);
      else if (roll < 15) n = $urandom_range(3, 8);
      else if (roll < 19) n = $urandom_range(9, 24);
      else                n = $urandom_range(25, 80);
      if (shape == SHAPE_RECT) n = 4;
      base_x = int'($urandom_range(0, 64000)) - 32000;
      base_y = int'($urandom_range(0, 64000)) - 32000;
      step_x = int'($urandom_range(0, 100)) - 50;
      step_y = int'($urandom_range(0, 100)) - 50;
      far_x  = coord_t'($urandom);
      far_y  = coord_t'($urandom);
      for (int i = 0; i < n; i++) begin
        case (shape)
          SHAPE_WILD: begin
            r.x = coord_t'($urandom);
            r.y = coord_t'($urandom);
          end
          SHAPE_CLUSTER: begin
            r.x = coord_t'(base_x + int'($urandom_range(0, 128)) - 64);
            r.y = coord_t'(base_y + int'($urandom_range(0, 128)) - 64);
          end
          SHAPE_EXTREME: begin
            r.x = pick_extreme();
            r.y = pick_extreme();
          end
          SHAPE_LINE: begin
            // Points scattered along one line, in no particular order.
            k   = $urandom_range(0, 20);
            r.x = coord_t'(base_x / 32 + k * step_x);
            r.y = coord_t'(base_y / 32 + k * step_y);
          end
          SHAPE_RECT: begin
            // Axis-aligned rectangle; the winding follows from the corners.
            r.x = (i == 1 || i == 2) ? far_x : coord_t'(base_x);
            r.y = (i >= 2) ? far_y : coord_t'(base_y);
          end
          default: begin
            r.x = coord_t'(base_x);
            r.y = coord_t'(base_y);
          end
        endcase
        r.last = (i == n - 1);
        send_vertex(r);
      end
      random_sent += n;
    end
    vertex_beats.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
